/* rtl/nmea_gga_pkg.sv */
package nmea_gga_pkg;

    localparam int FIELD_CHARS_DEF = 15;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] FID_TIME    = 3'd0;
    localparam logic [2:0] FID_LAT     = 3'd1;
    localparam logic [2:0] FID_LAT_DIR = 3'd2;
    localparam logic [2:0] FID_LON     = 3'd3;
    localparam logic [2:0] FID_LON_DIR = 3'd4;
    localparam logic [2:0] FID_ALT     = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [2:0] field_id;
        logic [3:0] char_index;
        logic [7:0] char_value;
        logic       sentence_ok;
        logic [7:0] computed_sum;
    } result_t;

endpackage

/* rtl/nmea_gga_in_stage.sv */
module nmea_gga_in_stage
    import nmea_gga_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign rx_stall = valid_reg && !advance;
    assign load     = rx_valid && !rx_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

/* rtl/nmea_gga_core.sv */
module nmea_gga_core
    import nmea_gga_pkg::*;
#(
    parameter int FIELD_CHARS = FIELD_CHARS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       advance,
    output logic       emit,
    output result_t    result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_HEX1,
        PH_HEX2
    } phase_t;

    localparam logic [2:0] HDR_LEN  = 3'd5;
    localparam logic [3:0] FC_MAX   = 4'd15;
    localparam logic [4:0] CP_MAX   = 5'd31;
    localparam logic [4:0] CP_LIMIT = 5'(FIELD_CHARS);

    phase_t     phase_reg, phase_next;
    logic [2:0] header_pos_reg, header_pos_next;
    logic       header_good_reg, header_good_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [3:0] field_count_reg, field_count_next;
    logic [4:0] char_pos_reg, char_pos_next;
    logic [3:0] sum_high_reg, sum_high_next;
    logic       high_valid_reg, high_valid_next;

    logic       fire;
    logic [4:0] hex;
    logic [7:0] xor_next_body;
    logic [2:0] fid;
    logic       fid_used;
    logic       single;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b1, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h47;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    assign fire          = item_valid && advance;
    assign hex           = hex_value(item_byte);
    assign xor_next_body = running_xor_reg ^ item_byte;

    always_comb
    begin
        fid      = FID_TIME;
        fid_used = 1'b1;
        single   = 1'b0;
        case (field_count_reg)
            4'd1:    fid = FID_TIME;
            4'd2:    fid = FID_LAT;
            4'd3:
            begin
                fid    = FID_LAT_DIR;
                single = 1'b1;
            end
            4'd4:    fid = FID_LON;
            4'd5:
            begin
                fid    = FID_LON_DIR;
                single = 1'b1;
            end
            4'd9:    fid = FID_ALT;
            default: fid_used = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        header_pos_next  = header_pos_reg;
        header_good_next = header_good_reg;
        running_xor_next = running_xor_reg;
        field_count_next = field_count_reg;
        char_pos_next    = char_pos_reg;
        sum_high_next    = sum_high_reg;
        high_valid_next  = high_valid_reg;
        emit             = 1'b0;
        result           = '0;
        if (fire)
        begin
            if (item_byte == CH_DOLLAR)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    emit                = 1'b1;
                    result.kind         = KIND_VERDICT;
                    result.computed_sum = running_xor_reg;
                end
                phase_next       = PH_BODY;
                header_pos_next  = '0;
                header_good_next = 1'b1;
                running_xor_next = '0;
                field_count_next = '0;
                char_pos_next    = '0;
                sum_high_next    = '0;
                high_valid_next  = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_BODY:
                    begin
                        if (item_byte == CH_STAR)
                        begin
                            if (header_pos_reg < HDR_LEN)
                            begin
                                header_good_next = 1'b0;
                            end
                            phase_next = PH_HEX1;
                        end
                        else
                        begin
                            running_xor_next = xor_next_body;
                            if (item_byte == CH_COMMA)
                            begin
                                if (header_pos_reg < HDR_LEN)
                                begin
                                    header_good_next = 1'b0;
                                    header_pos_next  = HDR_LEN;
                                end
                                if (field_count_reg < FC_MAX)
                                begin
                                    field_count_next = field_count_reg + 4'd1;
                                end
                                char_pos_next = '0;
                            end
                            else if (field_count_reg == 4'd0)
                            begin
                                if (header_pos_reg < HDR_LEN)
                                begin
                                    if (item_byte != hdr_char(header_pos_reg))
                                    begin
                                        header_good_next = 1'b0;
                                    end
                                    header_pos_next = header_pos_reg + 3'd1;
                                end
                                else
                                begin
                                    header_good_next = 1'b0;
                                end
                            end
                            else
                            begin
                                if (char_pos_reg < CP_MAX)
                                begin
                                    char_pos_next = char_pos_reg + 5'd1;
                                end
                                if (fid_used && (single ? (char_pos_reg == 5'd0)
                                                        : (char_pos_reg < CP_LIMIT)))
                                begin
                                    emit              = 1'b1;
                                    result.kind       = KIND_CHAR;
                                    result.field_id   = fid;
                                    result.char_index = char_pos_reg[3:0];
                                    result.char_value = item_byte;
                                end
                            end
                        end
                    end
                    PH_HEX1:
                    begin
                        high_valid_next = hex[4];
                        sum_high_next   = hex[3:0];
                        phase_next      = PH_HEX2;
                    end
                    PH_HEX2:
                    begin
                        emit                = 1'b1;
                        result.kind         = KIND_VERDICT;
                        result.computed_sum = running_xor_reg;
                        result.sentence_ok  = header_good_reg && (header_pos_reg == HDR_LEN)
                                              && high_valid_reg && hex[4]
                                              && ({sum_high_reg, hex[3:0]} == running_xor_reg);
                        phase_next          = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            header_pos_reg  <= '0;
            header_good_reg <= 1'b1;
            running_xor_reg <= '0;
            field_count_reg <= '0;
            char_pos_reg    <= '0;
            sum_high_reg    <= '0;
            high_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            header_pos_reg  <= header_pos_next;
            header_good_reg <= header_good_next;
            running_xor_reg <= running_xor_next;
            field_count_reg <= field_count_next;
            char_pos_reg    <= char_pos_next;
            sum_high_reg    <= sum_high_next;
            high_valid_reg  <= high_valid_next;
        end
    end

endmodule

/* rtl/nmea_gga_out_stage.sv */
module nmea_gga_out_stage
    import nmea_gga_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    emit,
    input  result_t result,
    output logic    advance,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign advance = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            data_reg <= result;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

/* rtl/nmea_gga_sentence_parser.sv */
// Path: an accepted byte is loaded into the input register and parsed by the core as it leaves
// it; any result is loaded into the result register and presented there until it is taken.
// Throughput: one byte per cycle while no result waits; while a result waits for res_stall
// to drop the parser holds, and rx_stall rises once the input register holds a byte.
// Reset: rst_n clears the valid flags and returns the parser to idle, waiting for a dollar.
module nmea_gga_sentence_parser
    import nmea_gga_pkg::*;
#(
    parameter int FIELD_CHARS = FIELD_CHARS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       kind,
    output logic [2:0] field_id,
    output logic [3:0] char_index,
    output logic [7:0] char_value,
    output logic       sentence_ok,
    output logic [7:0] computed_sum
);

    logic       advance;
    logic       item_valid;
    logic [7:0] item_byte;
    logic       emit;
    result_t    result;
    result_t    res_data;

    nmea_gga_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    nmea_gga_core #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .advance    (advance),
        .emit       (emit),
        .result     (result)
    );

    nmea_gga_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .result    (result),
        .advance   (advance),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    assign kind         = res_data.kind;
    assign field_id     = res_data.field_id;
    assign char_index   = res_data.char_index;
    assign char_value   = res_data.char_value;
    assign sentence_ok  = res_data.sentence_ok;
    assign computed_sum = res_data.computed_sum;

endmodule
